### rtl/core/utf8sd_pkg.sv
// ----------------------------------------------------------------------------
// utf8sd_pkg: shared types and constants of the six-byte UTF-8 decoder
// Widths of the code point and byte count, the decoder state record and
// the lead byte masks.
// ----------------------------------------------------------------------------
package utf8sd_pkg;

	localparam int unsigned BYTE_W = 8;
	localparam int unsigned CP_W   = 31;
	localparam int unsigned CNT_W  = 3;

	// Lead byte class masks, tested from the longest sequence down.
	localparam logic [BYTE_W-1:0] LEAD6_MASK = 8'hFC;
	localparam logic [BYTE_W-1:0] LEAD5_MASK = 8'hF8;
	localparam logic [BYTE_W-1:0] LEAD4_MASK = 8'hF0;
	localparam logic [BYTE_W-1:0] LEAD3_MASK = 8'hE0;
	localparam logic [BYTE_W-1:0] LEAD2_MASK = 8'hC0;
	localparam logic [BYTE_W-1:0] CONT_MASK  = 8'h3F;
	localparam logic [BYTE_W-1:0] ASCII_LIM  = 8'h80;

	// Lengths of the sequences.
	localparam logic [CNT_W-1:0] LEN_ONE   = 3'd1;
	localparam logic [CNT_W-1:0] LEN_TWO   = 3'd2;
	localparam logic [CNT_W-1:0] LEN_THREE = 3'd3;
	localparam logic [CNT_W-1:0] LEN_FOUR  = 3'd4;
	localparam logic [CNT_W-1:0] LEN_FIVE  = 3'd5;
	localparam logic [CNT_W-1:0] LEN_SIX   = 3'd6;

	// Sequence state carried from one word to the next.
	typedef struct packed {
		logic [CNT_W-1:0] pending;
		logic [CP_W-1:0]  partial;
		logic [CNT_W-1:0] size;
	} dec_state_t;

	// One decoded character.
	typedef struct packed {
		logic             emit;
		logic [CP_W-1:0]  code_point;
		logic [CNT_W-1:0] byte_count;
	} dec_result_t;

endpackage

### rtl/core/utf8sd_step.sv
// ----------------------------------------------------------------------------
// utf8sd_step: combinational decode of one byte
// Takes the current sequence state and one byte and gives the next state
// and, when a character completes, the decoded result.
// ----------------------------------------------------------------------------
module utf8sd_step
	import utf8sd_pkg::*;
(
	input  logic [BYTE_W-1:0] byte_in,
	input  dec_state_t        state_cur,
	output dec_state_t        state_nxt,
	output dec_result_t       result
);

	logic [CNT_W-1:0] pend_dec;
	logic [CP_W-1:0]  cont_bits;
	logic [5:0]       low6;

	assign low6     = byte_in[5:0] & CONT_MASK[5:0];
	assign pend_dec = state_cur.pending - 3'd1;

	// Place the six continuation bits by the number of bytes still to come.
	always_comb begin
		cont_bits = '0;
		case (pend_dec)
			3'd0: cont_bits[5:0]   = low6;
			3'd1: cont_bits[11:6]  = low6;
			3'd2: cont_bits[17:12] = low6;
			3'd3: cont_bits[23:18] = low6;
			3'd4: cont_bits[29:24] = low6;
			default: cont_bits = '0;
		endcase
	end

	// Continue an open sequence, or sort the byte as a lead.
	always_comb begin
		state_nxt = state_cur;
		result    = '0;
		if (state_cur.pending != '0) begin
			state_nxt.pending = pend_dec;
			state_nxt.partial = state_cur.partial | cont_bits;
			if (pend_dec == '0) begin
				result.emit       = 1'b1;
				result.code_point = state_cur.partial | cont_bits;
				result.byte_count = state_cur.size;
				state_nxt.partial = '0;
				state_nxt.size    = '0;
			end
		end else if (byte_in < ASCII_LIM) begin
			result.emit       = 1'b1;
			result.code_point = {{(CP_W-BYTE_W){1'b0}}, byte_in};
			result.byte_count = LEN_ONE;
		end else if ((byte_in & LEAD6_MASK) == LEAD6_MASK) begin
			state_nxt.pending = LEN_FIVE;
			state_nxt.size    = LEN_SIX;
			state_nxt.partial = {byte_in[0], 30'd0};
		end else if ((byte_in & LEAD5_MASK) == LEAD5_MASK) begin
			state_nxt.pending = LEN_FOUR;
			state_nxt.size    = LEN_FIVE;
			state_nxt.partial = {5'd0, byte_in[1:0], 24'd0};
		end else if ((byte_in & LEAD4_MASK) == LEAD4_MASK) begin
			state_nxt.pending = LEN_THREE;
			state_nxt.size    = LEN_FOUR;
			state_nxt.partial = {10'd0, byte_in[2:0], 18'd0};
		end else if ((byte_in & LEAD3_MASK) == LEAD3_MASK) begin
			state_nxt.pending = LEN_TWO;
			state_nxt.size    = LEN_THREE;
			state_nxt.partial = {15'd0, byte_in[3:0], 12'd0};
		end else if ((byte_in & LEAD2_MASK) == LEAD2_MASK) begin
			state_nxt.pending = LEN_ONE;
			state_nxt.size    = LEN_TWO;
			state_nxt.partial = {20'd0, byte_in[4:0], 6'd0};
		end else begin
			// A stray continuation byte is consumed and gives code point zero.
			result.emit       = 1'b1;
			result.code_point = '0;
			result.byte_count = LEN_ONE;
		end
	end

endmodule

### rtl/core/utf8_six_byte_decoder_core.sv
// ----------------------------------------------------------------------------
// utf8_six_byte_decoder_core: six-byte UTF-8 decoder
// Decodes a byte stream in the original UTF-8 form into 31-bit code points.
//
//   channel  direction  payload                 handshake
//   in       input      in_byte                 in_valid / in_stall
//   out      output     code_point, byte_count  out_valid / out_stall
//
// A byte is registered on acceptance and decoded from the input register into the
// output register, so a character word passes both registers after its last byte.
// One byte is taken in every cycle while the output is not stalled; the state
// update of the sequence registers, once per byte, sets that rate.
// Reset clears the sequence state and both valid flags.
// A stalled output word holds the pipeline; the input stalls only while its
// register is full and cannot advance.
// ----------------------------------------------------------------------------
module utf8_six_byte_decoder_core
	import utf8sd_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic [BYTE_W-1:0] in_byte,
	input  logic              in_valid,
	output logic              in_stall,
	output logic [CP_W-1:0]   code_point,
	output logic [CNT_W-1:0]  byte_count,
	output logic              out_valid,
	input  logic              out_stall
);

	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic              valid_s2;
	logic [CP_W-1:0]   cp_s2;
	logic [CNT_W-1:0]  cnt_s2;
	dec_state_t        state_q;
	dec_state_t        state_nxt;
	dec_result_t       result;
	logic              advance;

	// The decode stage moves whenever the output register is free or taken.
	assign advance  = !(valid_s2 && out_stall);
	assign in_stall = valid_s1 && !advance;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			byte_s1 <= in_byte;
		end
	end

	// Decode of the registered byte.
	utf8sd_step u_step (
		.byte_in   (byte_s1),
		.state_cur (state_q),
		.state_nxt (state_nxt),
		.result    (result)
	);

	// Sequence state, updated as each byte leaves the input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (valid_s1 && advance) begin
			state_q <= state_nxt;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1 && result.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1 && result.emit) begin
			cp_s2  <= result.code_point;
			cnt_s2 <= result.byte_count;
		end
	end

	assign out_valid  = valid_s2;
	assign code_point = cp_s2;
	assign byte_count = cnt_s2;

	// An open sequence always has more bytes in total than it still expects.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q.pending != '0) |-> (state_q.size > state_q.pending))
		else $error("sequence size not above pending count");

	// With no sequence open the gathered bits and size are cleared.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q.pending == '0) |-> (state_q.partial == '0 && state_q.size == '0))
		else $error("idle sequence state not cleared");

	// Every output word carries a length of one to six bytes.
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> (cnt_s2 >= LEN_ONE && cnt_s2 <= LEN_SIX))
		else $error("byte count out of range");

	// A single-byte word never carries a value above seven bits.
	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && cnt_s2 == LEN_ONE) |-> (cp_s2[CP_W-1:7] == '0))
		else $error("single byte word too wide");

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the six-byte UTF-8 decoder
// A queue of bytes (a directed set, then random sequences with some noise)
// feeds a clocked driver. A byte-level decoder model in the bench predicts
// each character word on acceptance, and a clocked monitor checks every
// output word against the oldest prediction. Both sides idle at random.
// ----------------------------------------------------------------------------
module testbench;
	import utf8sd_pkg::*;

	localparam int CYCLE_LIMIT  = 200000;
	localparam int RANDOM_BYTES = 1950;

	typedef struct packed {
		logic [CP_W-1:0]  code_point;
		logic [CNT_W-1:0] byte_count;
	} char_word_t;

	typedef struct packed {
		logic [BYTE_W-1:0] value;
		logic              drain_first;
	} stream_byte_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic [BYTE_W-1:0] in_byte = '0;
	logic              in_valid = 1'b0;
	logic              in_stall;
	logic [CP_W-1:0]   code_point;
	logic [CNT_W-1:0]  byte_count;
	logic              out_valid;
	logic              out_stall = 1'b0;

	// Stimulus and prediction stores.
	stream_byte_t byte_queue[$];
	char_word_t   expected_chars[$];
	char_word_t   oldest_char;

	// Decoder model state.
	logic [CNT_W-1:0] cont_left = '0;
	logic [CP_W-1:0]  gathered_bits = '0;
	logic [CNT_W-1:0] open_length = '0;

	// Handshake bookkeeping.
	bit byte_busy = 1'b0;
	int gap_left = 0;
	int stall_left = 0;
	bit send_steady = 1'b0;
	bit take_steady = 1'b0;
	int error_count = 0;
	int cycle_count = 0;

	utf8_six_byte_decoder_core DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_byte    (in_byte),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.code_point (code_point),
		.byte_count (byte_count),
		.out_valid  (out_valid),
		.out_stall  (out_stall)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
	end

	// Opens a sequence: the lead payload goes above the bits of all continuations.
	function automatic void open_sequence(input logic [CNT_W-1:0] length,
			input logic [4:0] payload);
		logic [CP_W-1:0] widened;
		widened = CP_W'(payload);
		cont_left = length - 1'b1;
		open_length = length;
		gathered_bits = widened << (6 * (length - 1));
	endfunction

	// Decoder model: consumes one accepted byte and queues the character it ends.
	function automatic void decode_byte(input logic [BYTE_W-1:0] b);
		logic [CP_W-1:0] low_bits;
		low_bits = CP_W'(b & CONT_MASK);
		if (cont_left != 0) begin
			cont_left = cont_left - 1'b1;
			gathered_bits = gathered_bits | (low_bits << (6 * cont_left));
			if (cont_left == 0) begin
				expected_chars.push_back('{gathered_bits, open_length});
				gathered_bits = '0;
				open_length = '0;
			end
		end else if (b < ASCII_LIM) begin
			expected_chars.push_back('{CP_W'(b), LEN_ONE});
		end else if ((b & LEAD6_MASK) == LEAD6_MASK) begin
			open_sequence(LEN_SIX, 5'(b[0]));
		end else if ((b & LEAD5_MASK) == LEAD5_MASK) begin
			open_sequence(LEN_FIVE, 5'(b[1:0]));
		end else if ((b & LEAD4_MASK) == LEAD4_MASK) begin
			open_sequence(LEN_FOUR, 5'(b[2:0]));
		end else if ((b & LEAD3_MASK) == LEAD3_MASK) begin
			open_sequence(LEN_THREE, 5'(b[3:0]));
		end else if ((b & LEAD2_MASK) == LEAD2_MASK) begin
			open_sequence(LEN_TWO, b[4:0]);
		end else begin
			// A stray continuation byte stands for a character of value zero.
			expected_chars.push_back('{'0, LEN_ONE});
		end
	endfunction

	function automatic void queue_bytes(input logic [BYTE_W-1:0] values[$]);
		foreach (values[i]) byte_queue.push_back('{values[i], 1'b0});
	endfunction

	// Appends one random sequence: mostly well formed, sometimes noise or cut short.
	function automatic void queue_random_sequence();
		int roll;
		int length;
		int conts;
		logic [BYTE_W-1:0] lead;
		roll = $urandom_range(0, 99);
		if (roll < 12) begin
			byte_queue.push_back('{BYTE_W'($urandom_range(0, 255)), 1'b0});
			return;
		end
		length = $urandom_range(1, 6);
		case (length)
			1: lead = BYTE_W'($urandom_range(8'h00, 8'h7F));
			2: lead = BYTE_W'($urandom_range(8'hC0, 8'hDF));
			3: lead = BYTE_W'($urandom_range(8'hE0, 8'hEF));
			4: lead = BYTE_W'($urandom_range(8'hF0, 8'hF7));
			5: lead = BYTE_W'($urandom_range(8'hF8, 8'hFB));
			default: lead = BYTE_W'($urandom_range(8'hFC, 8'hFF));
		endcase
		byte_queue.push_back('{lead, 1'b0});
		conts = length - 1;
		if (roll < 16 && conts > 0) conts = $urandom_range(0, conts - 1);
		for (int i = 0; i < conts; i++) begin
			if ($urandom_range(0, 9) == 0)
				byte_queue.push_back('{BYTE_W'($urandom_range(0, 255)), 1'b0});
			else
				byte_queue.push_back('{BYTE_W'($urandom_range(8'h80, 8'hBF)), 1'b0});
		end
	endfunction

	// Driver: offers the next queued byte at the falling edge.
	always @(negedge clk) begin
		if (arst_n && !byte_busy) begin
			if (gap_left != 0) begin
				gap_left--;
				in_valid <= 1'b0;
			end else if (byte_queue.size() != 0 &&
					!(byte_queue[0].drain_first && expected_chars.size() != 0)) begin
				in_byte <= byte_queue[0].value;
				in_valid <= 1'b1;
				byte_queue.pop_front();
				byte_busy = 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Input acceptance: predict the result and draw the gap before the next byte.
	always @(posedge clk) begin
		if (arst_n && in_valid && !in_stall) begin
			decode_byte(in_byte);
			byte_busy = 1'b0;
			if ($urandom_range(0, 99) == 0) send_steady = !send_steady;
			gap_left = send_steady ? 0 : $urandom_range(0, 4);
		end
	end

	// Receiver stall, driven at the falling edge.
	always @(negedge clk) begin
		if (arst_n && stall_left != 0) begin
			stall_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	// Monitor: checks each accepted word against the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (expected_chars.size() == 0) begin
				$display("%0t: unexpected word, expected none, actual %h / %0d",
					$time, code_point, byte_count);
				error_count++;
			end else begin
				oldest_char = expected_chars.pop_front();
				if (code_point !== oldest_char.code_point) begin
					$display("%0t: code_point mismatch, expected %h, actual %h",
						$time, oldest_char.code_point, code_point);
					error_count++;
				end
				if (byte_count !== oldest_char.byte_count) begin
					$display("%0t: byte_count mismatch, expected %0d, actual %0d",
						$time, oldest_char.byte_count, byte_count);
					error_count++;
				end
			end
			if ($urandom_range(0, 99) == 0) take_steady = !take_steady;
			stall_left = take_steady ? 0 : $urandom_range(0, 4);
		end
	end

	// Watchdog on the cycle counter.
	initial begin
		while (cycle_count < CYCLE_LIMIT) @(posedge clk);
		$display("DONE: errors detected");
		$finish;
	end

	// Stimulus, reset and end of run.
	initial begin
		// Plain bytes at both ends and stray continuations at both ends.
		queue_bytes('{8'h00, 8'h7F, 8'h80, 8'hBF});
		// Smallest two-byte lead; three bytes with a lead and a plain byte
		// as continuations.
		queue_bytes('{8'hC0, 8'h80, 8'hE0, 8'hFF, 8'h00});
		// Largest four-byte sequence; five bytes with badly tagged continuations.
		queue_bytes('{8'hF7, 8'hBF, 8'hBF, 8'hBF});
		queue_bytes('{8'hF8, 8'h80, 8'hC1, 8'h7F, 8'h3F});
		// Six bytes led by 0xFF, which counts as a six-byte lead.
		queue_bytes('{8'hFF, 8'hBF, 8'h80, 8'hFF, 8'h00, 8'hBF});
		// Let every earlier character drain before the last directed sequence, and again near the middle of the random part.
		byte_queue.push_back('{8'hFC, 1'b1});
		queue_bytes('{8'hBF, 8'hBF, 8'hBF, 8'hBF, 8'hBF});
		while (byte_queue.size() < RANDOM_BYTES + 30) begin
			queue_random_sequence();
			if (byte_queue.size() > RANDOM_BYTES / 2 &&
					byte_queue.size() < RANDOM_BYTES / 2 + 4)
				byte_queue[byte_queue.size() - 1].drain_first = 1'b1;
		end

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (byte_queue.size() != 0 || byte_busy || expected_chars.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		if (error_count == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
